// ===== rtl/irc_tok_pkg.sv =====
// Shared types and character constants for the IRC line tokenizer.
package irc_tok_pkg;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_PREFIX = 3'd1,
      PH_CMD    = 3'd2,
      PH_SEEK   = 3'd3,
      PH_MIDDLE = 3'd4,
      PH_TRAIL  = 3'd5,
      PH_DROP   = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_PREFIX = 3'd1,
      KIND_CMD    = 3'd2,
      KIND_MIDDLE = 3'd3,
      KIND_TRAIL  = 3'd4
   } kind_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  param_cnt;
      logic        trail_flag;
      logic        after_delim;
      logic [9:0]  byte_cnt;
   } state_type;

   typedef struct packed {
      logic [7:0]  echo_byte;
      kind_type    field_kind;
      logic [3:0]  param_index;
      logic        field_start;
      logic        line_end;
      logic [3:0]  param_count;
      logic        trailing_seen;
      logic [9:0]  line_length;
   } result_type;

   localparam state_type STATE_LINE_START = '{PH_START, 4'd0, 1'b0, 1'b0, 10'd0};

endpackage

// ===== rtl/irc_tok_step.sv =====
// Per-byte parse step: next tokenizer state and the labelled result beat.
module irc_tok_step
   import irc_tok_pkg::*;
#(
   parameter int PARAM_LIMIT  = 15,
   parameter int LENGTH_LIMIT = 512
) (
   input  logic [7:0] data_byte,
   input  state_type  cur,
   output state_type  nxt,
   output result_type res
);

   logic sp;
   logic cr;

   always_comb begin
      sp  = (data_byte == CHAR_SPACE);
      cr  = (data_byte == CHAR_CR);
      nxt = cur;
      res = '0;
      res.echo_byte  = data_byte;
      res.field_kind = KIND_NONE;

      if (data_byte == CHAR_LF) begin
         // Report the line summary and return to line start
         res.line_end      = 1'b1;
         res.param_count   = cur.param_cnt;
         res.trailing_seen = cur.trail_flag;
         res.line_length   = cur.byte_cnt;
         nxt               = STATE_LINE_START;
      end else begin
         if (cur.byte_cnt < 10'(LENGTH_LIMIT)) begin
            nxt.byte_cnt = cur.byte_cnt + 10'd1;
         end
         case (cur.phase)
            PH_START: begin
               if (data_byte == CHAR_COLON) begin
                  nxt.phase       = PH_PREFIX;
                  nxt.after_delim = 1'b1;
               end else if (sp || cr) begin
                  nxt.phase       = PH_CMD;
                  nxt.after_delim = 1'b1;
               end else begin
                  nxt.phase       = PH_CMD;
                  nxt.after_delim = 1'b0;
                  res.field_kind  = KIND_CMD;
                  res.field_start = 1'b1;
               end
            end
            PH_PREFIX: begin
               // Only a space ends the prefix
               if (sp) begin
                  if (!cur.after_delim) begin
                     nxt.phase = PH_CMD;
                  end
                  nxt.after_delim = 1'b1;
               end else begin
                  res.field_kind  = KIND_PREFIX;
                  res.field_start = cur.after_delim;
                  nxt.after_delim = 1'b0;
               end
            end
            PH_CMD: begin
               if (sp || cr) begin
                  if (!cur.after_delim) begin
                     nxt.phase       = PH_SEEK;
                     nxt.after_delim = 1'b1;
                  end
               end else begin
                  res.field_kind  = KIND_CMD;
                  res.field_start = cur.after_delim;
                  nxt.after_delim = 1'b0;
               end
            end
            PH_SEEK: begin
               if (cur.param_cnt >= 4'(PARAM_LIMIT)) begin
                  nxt.phase       = PH_DROP;
                  nxt.after_delim = 1'b0;
               end else if (data_byte == CHAR_COLON && cur.after_delim) begin
                  nxt.param_cnt   = cur.param_cnt + 4'd1;
                  nxt.trail_flag  = 1'b1;
                  nxt.phase       = PH_TRAIL;
                  nxt.after_delim = 1'b1;
               end else if (sp || cr) begin
                  nxt.after_delim = 1'b0;
               end else begin
                  res.param_index = cur.param_cnt;
                  nxt.param_cnt   = cur.param_cnt + 4'd1;
                  nxt.phase       = PH_MIDDLE;
                  nxt.after_delim = 1'b0;
                  res.field_kind  = KIND_MIDDLE;
                  res.field_start = 1'b1;
               end
            end
            PH_MIDDLE: begin
               if (sp || cr) begin
                  nxt.phase       = PH_SEEK;
                  nxt.after_delim = 1'b1;
               end else begin
                  res.field_kind  = KIND_MIDDLE;
                  res.param_index = cur.param_cnt - 4'd1;
               end
            end
            PH_TRAIL: begin
               if (cr) begin
                  nxt.phase       = PH_SEEK;
                  nxt.after_delim = 1'b1;
               end else begin
                  res.field_kind  = KIND_TRAIL;
                  res.param_index = cur.param_cnt - 4'd1;
                  res.field_start = cur.after_delim;
                  nxt.after_delim = 1'b0;
               end
            end
            default: begin
               // Drop everything up to the newline
               nxt.phase = PH_DROP;
            end
         endcase
      end
   end

endmodule

// ===== rtl/irc_line_tokenizer_core.sv =====
// Top level of the IRC line tokenizer: input register, parse step, result register.
// A byte accepted passes through the input register and then the result register before it appears on the rsp_ channel.
// Throughput: one byte per cycle, sustained while rsp_stall stays low.
// The parse state advances as the input register hands its beat to the result register.
// Reset is synchronous and active high; it returns the parser to line start and
// empties both registers. No clearing pass is needed.
module irc_line_tokenizer_core
   import irc_tok_pkg::*;
#(
   parameter int PARAM_LIMIT  = 15,
   parameter int LENGTH_LIMIT = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_echo_byte,
   output logic [2:0] rsp_field_kind,
   output logic [3:0] rsp_param_index,
   output logic       rsp_field_start,
   output logic       rsp_line_end,
   output logic [3:0] rsp_param_count,
   output logic       rsp_trailing_seen,
   output logic [9:0] rsp_line_length
);

   // Input register: holds one accepted beat until the result register can take it
   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;

   // Parser state, advanced once per byte that moves into the result register
   state_type  state_ff;
   state_type  state_in;

   // Result register
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type step_res;

   logic       req_take;
   logic       advance;
   logic       rsp_take;

   // The result register is free if empty or being drained this cycle
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   // Stall the requester only while a held beat cannot move on
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   irc_tok_step #(
      .PARAM_LIMIT  (PARAM_LIMIT),
      .LENGTH_LIMIT (LENGTH_LIMIT)
   ) u_step (
      .data_byte (in_byte_ff),
      .cur       (state_ff),
      .nxt       (state_in),
      .res       (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_LINE_START;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         // Advance the parser only when its beat is committed to the result register
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers: no reset, load only on their handshake
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
      end
      if (advance) begin
         out_ff <= step_res;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_echo_byte     = out_ff.echo_byte;
   assign rsp_field_kind    = out_ff.field_kind;
   assign rsp_param_index   = out_ff.param_index;
   assign rsp_field_start   = out_ff.field_start;
   assign rsp_line_end      = out_ff.line_end;
   assign rsp_param_count   = out_ff.param_count;
   assign rsp_trailing_seen = out_ff.trailing_seen;
   assign rsp_line_length   = out_ff.line_length;

`ifndef SYNTHESIS
   // A newline beat must leave the parser at line start
   assert property (@(posedge clock) disable iff (reset)
      advance && step_res.line_end |=> state_ff == STATE_LINE_START)
      else $error("parser not back at line start after newline");

   // The byte count saturates at the length limit
   assert property (@(posedge clock) disable iff (reset)
      state_ff.byte_cnt <= 10'(LENGTH_LIMIT))
      else $error("byte count beyond length limit");

   // The parameter count never passes the parameter limit
   assert property (@(posedge clock) disable iff (reset)
      state_ff.param_cnt <= 4'(PARAM_LIMIT))
      else $error("parameter count beyond limit");

   // Parser state holds while no beat moves into the result register
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("parser state changed without a beat");

   // A stalled request side always has a beat waiting in the input register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled without a blocked beat");
`endif

endmodule

// ===== dv/irc_line_tokenizer_core_test.sv =====
// Self-checking testbench for the IRC line tokenizer core: directed table, random lines.
module irc_line_tokenizer_core_test;
   import irc_tok_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PARAM_LIMIT  = 15;
   localparam int LENGTH_LIMIT = 512;
   // Give up once this many cycles pass without a beat on either channel.
   localparam int QUIET_LIMIT  = 2000;
   // A byte accepted passes the input and result registers before it shows up; allow a margin.
   localparam int SETTLE_CYCLES = 10;

   // One row of the directed tour: a byte, plus a hand-typed result where the
   // outcome is obvious from the line so far.
   typedef struct packed {
      logic [7:0] data;
      logic       typed;
      result_type want;
   } tour_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_echo_byte;
   logic [2:0] rsp_field_kind;
   logic [3:0] rsp_param_index;
   logic       rsp_field_start;
   logic       rsp_line_end;
   logic [3:0] rsp_param_count;
   logic       rsp_trailing_seen;
   logic [9:0] rsp_line_length;

   // Tokenizer state mirrored by the testbench.
   phase_type  ph;
   logic [3:0] params_open;
   logic       trail_open;
   logic       one_delim;
   logic [9:0] consumed;

   result_type expected_tokens[$];
   result_type oldest;
   logic [7:0] line_bytes[$];
   tour_row_type tour [25];

   int errors = 0;
   int beats_checked = 0;
   int bytes_sent = 0;
   int lines_seen = 0;
   int capped_lines = 0;
   int saturated_lines = 0;
   int trailing_lines = 0;
   int tx_pct = 0;
   int rx_pct = 0;
   int quiet_cycles = 0;

   irc_line_tokenizer_core #(
      .PARAM_LIMIT (PARAM_LIMIT),
      .LENGTH_LIMIT(LENGTH_LIMIT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_echo_byte    (rsp_echo_byte),
      .rsp_field_kind   (rsp_field_kind),
      .rsp_param_index  (rsp_param_index),
      .rsp_field_start  (rsp_field_start),
      .rsp_line_end     (rsp_line_end),
      .rsp_param_count  (rsp_param_count),
      .rsp_trailing_seen(rsp_trailing_seen),
      .rsp_line_length  (rsp_line_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      $display("mismatch on %s at beat %0d: got %0h, want %0h", what, beats_checked, got,
               want);
   endtask

   // Label one byte and advance the mirrored parse state.
   task automatic tokenize_byte(input logic [7:0] b, output result_type r);
      logic sp;
      logic cr;
      sp = (b == CHAR_SPACE);
      cr = (b == CHAR_CR);
      r = '0;
      r.echo_byte = b;
      r.field_kind = KIND_NONE;
      if (b == CHAR_LF) begin
         // Newline ends the line in any phase: report the summary, then go back to line start.
         r.line_end      = 1'b1;
         r.param_count   = params_open;
         r.trailing_seen = trail_open;
         r.line_length   = consumed;
         lines_seen++;
         if (params_open == PARAM_LIMIT) capped_lines++;
         if (consumed == LENGTH_LIMIT) saturated_lines++;
         if (trail_open) trailing_lines++;
         ph          = PH_START;
         params_open = '0;
         trail_open  = 1'b0;
         one_delim   = 1'b0;
         consumed    = '0;
      end else begin
         if (consumed < LENGTH_LIMIT) consumed++;
         case (ph)
            PH_START: begin
               if (b == CHAR_COLON) begin
                  ph        = PH_PREFIX;
                  one_delim = 1'b1;
               end else if (sp || cr) begin
                  // Leading delimiters: the command has not started yet.
                  ph        = PH_CMD;
                  one_delim = 1'b1;
               end else begin
                  ph            = PH_CMD;
                  one_delim     = 1'b0;
                  r.field_kind  = KIND_CMD;
                  r.field_start = 1'b1;
               end
            end
            PH_PREFIX: begin
               // Only a space closes the prefix; a CR is part of it.
               if (sp) begin
                  if (!one_delim) ph = PH_CMD;
                  one_delim = 1'b1;
               end else begin
                  r.field_kind  = KIND_PREFIX;
                  r.field_start = one_delim;
                  one_delim     = 1'b0;
               end
            end
            PH_CMD: begin
               if (sp || cr) begin
                  if (!one_delim) begin
                     ph        = PH_SEEK;
                     one_delim = 1'b1;
                  end
               end else begin
                  r.field_kind  = KIND_CMD;
                  r.field_start = one_delim;
                  one_delim     = 1'b0;
               end
            end
            PH_SEEK: begin
               if (params_open >= PARAM_LIMIT) begin
                  // Parameter cap reached: drop everything up to the newline.
                  ph        = PH_DROP;
                  one_delim = 1'b0;
               end else if (b == CHAR_COLON && one_delim) begin
                  // Trailing parameter counts even if nothing follows the colon.
                  params_open++;
                  trail_open = 1'b1;
                  ph         = PH_TRAIL;
                  one_delim  = 1'b1;
               end else if (sp || cr) begin
                  one_delim = 1'b0;
               end else begin
                  r.param_index = params_open;
                  params_open++;
                  ph            = PH_MIDDLE;
                  one_delim     = 1'b0;
                  r.field_kind  = KIND_MIDDLE;
                  r.field_start = 1'b1;
               end
            end
            PH_MIDDLE: begin
               if (sp || cr) begin
                  ph        = PH_SEEK;
                  one_delim = 1'b1;
               end else begin
                  r.field_kind  = KIND_MIDDLE;
                  r.param_index = params_open - 4'd1;
               end
            end
            PH_TRAIL: begin
               // A CR closes the trailing parameter; later bytes parse as between parameters.
               if (cr) begin
                  ph        = PH_SEEK;
                  one_delim = 1'b1;
               end else begin
                  r.field_kind  = KIND_TRAIL;
                  r.param_index = params_open - 4'd1;
                  r.field_start = one_delim;
                  one_delim     = 1'b0;
               end
            end
            default: ph = PH_DROP;
         endcase
      end
   endtask

   function automatic tour_row_type plain(input logic [7:0] b);
      tour_row_type row;
      row       = '0;
      row.data  = b;
      row.typed = 1'b0;
      return row;
   endfunction

   function automatic tour_row_type line_end_row(input logic [3:0] cnt, input logic trl,
                                                 input logic [9:0] len);
      tour_row_type row;
      row                    = '0;
      row.data               = CHAR_LF;
      row.typed              = 1'b1;
      row.want.echo_byte     = CHAR_LF;
      row.want.field_kind    = KIND_NONE;
      row.want.line_end      = 1'b1;
      row.want.param_count   = cnt;
      row.want.trailing_seen = trl;
      row.want.line_length   = len;
      return row;
   endfunction

   function automatic logic [7:0] token_byte(input bit allow_cr, input bit allow_space);
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CHAR_LF || (!allow_cr && b == CHAR_CR) || (!allow_space && b == CHAR_SPACE));
      return b;
   endfunction

   task automatic push_token(input int n, input bit allow_cr, input bit allow_space);
      repeat (n) line_bytes.push_back(token_byte(allow_cr, allow_space));
   endtask

   // Build one line: mostly well-formed messages with random content, some noise.
   task automatic compose_line(input bit long_line);
      int n;
      line_bytes.delete();
      if (!long_line && $urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 40);
         repeat (n) begin
            case ($urandom_range(0, 5))
               0:       line_bytes.push_back(CHAR_SPACE);
               1:       line_bytes.push_back(CHAR_CR);
               2:       line_bytes.push_back(CHAR_COLON);
               default: line_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         if ($urandom_range(0, 3) == 0)
            line_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_CR);
         if ($urandom_range(0, 1)) begin
            line_bytes.push_back(CHAR_COLON);
            push_token($urandom_range(1, 8), 1'b1, 1'b0);
            line_bytes.push_back(CHAR_SPACE);
            if ($urandom_range(0, 3) == 0) line_bytes.push_back(CHAR_SPACE);
         end
         push_token($urandom_range(1, 6), 1'b0, 1'b0);
         // Now and then run past the parameter cap.
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 17) : $urandom_range(0, 4);
         repeat (n) begin
            case ($urandom_range(0, 5))
               0: begin
                  line_bytes.push_back(CHAR_SPACE);
                  line_bytes.push_back(CHAR_SPACE);
               end
               1:       line_bytes.push_back(CHAR_CR);
               default: line_bytes.push_back(CHAR_SPACE);
            endcase
            push_token($urandom_range(1, 6), 1'b0, 1'b0);
         end
         if (long_line || $urandom_range(0, 1)) begin
            line_bytes.push_back(CHAR_SPACE);
            line_bytes.push_back(CHAR_COLON);
            push_token(long_line ? 530 : $urandom_range(0, 12), 1'b0, 1'b1);
         end
         if ($urandom_range(0, 99) < 70) line_bytes.push_back(CHAR_CR);
         if ($urandom_range(0, 4) == 0) push_token($urandom_range(1, 4), 1'b1, 1'b1);
      end
      line_bytes.push_back(CHAR_LF);
   endtask

   // Offer one byte, hold it until the block takes it, then log the expected result.
   task automatic send_byte(input logic [7:0] b, input logic typed, input result_type want);
      result_type predicted;
      while ($urandom_range(0, 99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokenize_byte(b, predicted);
      expected_tokens.push_back(typed ? want : predicted);
      bytes_sent++;
   endtask

   // Drop valid and hold off until every outstanding result has been taken.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   task automatic run_lines(input int upto, input bit long_first);
      bit long_line;
      long_line = long_first;
      while (bytes_sent < upto) begin
         compose_line(long_line);
         long_line = 1'b0;
         foreach (line_bytes[i]) send_byte(line_bytes[i], 1'b0, '0);
      end
   endtask

   // Result side: check each beat against the oldest expectation, stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch("beat with nothing expected", rsp_echo_byte, 0);
            end else begin
               oldest = expected_tokens.pop_front();
               if (rsp_echo_byte !== oldest.echo_byte)
                  report_mismatch("echo_byte", rsp_echo_byte, oldest.echo_byte);
               if (rsp_field_kind !== oldest.field_kind)
                  report_mismatch("field_kind", rsp_field_kind, oldest.field_kind);
               if (rsp_param_index !== oldest.param_index)
                  report_mismatch("param_index", rsp_param_index, oldest.param_index);
               if (rsp_field_start !== oldest.field_start)
                  report_mismatch("field_start", rsp_field_start, oldest.field_start);
               if (rsp_line_end !== oldest.line_end)
                  report_mismatch("line_end", rsp_line_end, oldest.line_end);
               if (rsp_param_count !== oldest.param_count)
                  report_mismatch("param_count", rsp_param_count, oldest.param_count);
               if (rsp_trailing_seen !== oldest.trailing_seen)
                  report_mismatch("trailing_seen", rsp_trailing_seen, oldest.trailing_seen);
               if (rsp_line_length !== oldest.line_length)
                  report_mismatch("line_length", rsp_line_length, oldest.line_length);
            end
            beats_checked++;
         end
         rsp_stall <= ($urandom_range(0, 99) < rx_pct);
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d results outstanding", QUIET_LIMIT,
                  expected_tokens.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      ph          = PH_START;
      params_open = '0;
      trail_open  = 1'b0;
      one_delim   = 1'b0;
      consumed    = '0;

      // Directed tour: newline straight after reset, extreme bytes, an empty trailing
      // parameter, a CR inside the prefix, leading delimiters, newline inside a trailing
      // parameter and inside a prefix.
      tour = '{
         line_end_row(4'd0, 1'b0, 10'd0),
         '{8'hFF, 1'b1, '{8'hFF, KIND_CMD, 4'd0, 1'b1, 1'b0, 4'd0, 1'b0, 10'd0}},
         plain(CHAR_SPACE), plain(CHAR_COLON), plain(CHAR_CR),
         line_end_row(4'd1, 1'b1, 10'd4),
         plain(CHAR_COLON), plain(CHAR_SPACE), plain(CHAR_CR), plain(CHAR_SPACE),
         plain(8'h41), plain(CHAR_SPACE), plain(CHAR_SPACE), plain(CHAR_COLON),
         line_end_row(4'd1, 1'b0, 10'd8),
         plain(CHAR_SPACE), plain(CHAR_CR), plain(8'h7E), plain(CHAR_SPACE),
         plain(CHAR_COLON), plain(CHAR_SPACE),
         line_end_row(4'd1, 1'b1, 10'd6),
         plain(CHAR_COLON), plain(8'h80),
         line_end_row(4'd0, 1'b0, 10'd2)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender sparse, receiver busy.
      tx_pct = 27;
      rx_pct = 69;
      foreach (tour[i]) send_byte(tour[i].data, tour[i].typed, tour[i].want);
      run_lines(400, 1'b0);
      hold_until_drained();

      // Sender busy, receiver sparse.
      tx_pct = 69;
      rx_pct = 27;
      run_lines(800, 1'b0);
      hold_until_drained();

      // Full rate both sides; open with a line long enough to saturate the length count.
      tx_pct = 0;
      rx_pct = 0;
      run_lines(1200, 1'b1);
      req_valid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d bytes over %0d lines, %0d beats checked", bytes_sent, lines_seen,
               beats_checked);
      $display("%0d lines hit the parameter cap, %0d saturated the length, %0d had a trailer",
               capped_lines, saturated_lines, trailing_lines);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
